FILE: rtl/dfs_pkg.sv
`default_nettype none
package dfs_pkg;
  localparam int DefMaxVertices = 64;
  localparam int DefMaxEdges    = 256;
  localparam int VidW           = 6;
  localparam int CntW           = 7;
endpackage
`default_nettype wire

FILE: rtl/dfs_topological_sort.sv
`default_nettype none
// edge beat: one edge per cycle back to back while the block is idle and holds no output beat
// sort beat: its accept clears the visited marks; S_CLR, then S_ROOT per root, S_RWAIT, S_PUSH
//   per new root; S_TOP to S_STEP per pop or edge, then S_EWAIT, S_EDGE, and S_EMIT2 on a push
// order: one vertex per unstalled cycle from the registered finish read; the input
//   stalls until the last beat has left
// reset (rst_n, synchronous): clears head valid bits, edge count, drop flag, vertex count
module dfs_topological_sort
  import dfs_pkg::*;
#(
  parameter int MaxVertices = DefMaxVertices,
  parameter int MaxEdges    = DefMaxEdges
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [CntW-1:0] cfg_vertex_count,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            in_cmd,
  input  wire logic [VidW-1:0] in_src_vertex,
  input  wire logic [VidW-1:0] in_dst_vertex,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [VidW-1:0]      out_vertex_id,
  output logic                 out_last_of_order,
  output logic                 out_edges_dropped
);
  localparam int VW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int EW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int EcW = $clog2(MaxEdges + 1);
  localparam int VcW = $clog2(MaxVertices + 1);
  localparam int FrW = VW + EW + 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_ROOT = 4'd2, S_RWAIT = 4'd3,
    S_PUSH = 4'd4, S_TOP = 4'd5, S_TWAIT = 4'd6, S_STEP = 4'd7, S_EWAIT = 4'd8,
    S_EDGE = 4'd9, S_EMIT = 4'd10, S_EMIT2 = 4'd11;

  logic [3:0]      st_r, st_nxt;
  logic [CntW-1:0] vcnt_r;
  logic [EcW-1:0]  ecnt_r;
  logic            drop_r;
  logic [MaxVertices-1:0] hvalid_r, visit_r;
  logic [VcW-1:0]  root_r, sp_r, fcnt_r, k_r;
  logic [VW-1:0]   tv_r;
  logic [FrW-1:0]  top_r;
  logic            ov_r, olast_r;
  logic [VcW-1:0]  ok_r;

  logic [VcW-1:0] neff;
  assign neff = (vcnt_r > CntW'(MaxVertices)) ? VcW'(MaxVertices) : VcW'(vcnt_r);

  // memories
  logic            h_we, e_we, s_we, f_we;
  logic [VW-1:0]   h_wa, h_ra, s_wa, s_ra, f_wa, f_ra;
  logic [EW-1:0]   h_wd, h_rd, e_wa, e_ra;
  logic [FrW-1:0]  e_wd, e_rd;
  logic [FrW-1:0]  s_wd, s_rd;
  logic [VW-1:0]   f_wd, f_rd;

  dfs_ram #(.Width(EW), .Depth(MaxVertices)) u_head (.clk, .we(h_we), .waddr(h_wa),
    .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  dfs_ram #(.Width(FrW), .Depth(MaxEdges)) u_edge (.clk, .we(e_we), .waddr(e_wa),
    .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  dfs_ram #(.Width(FrW), .Depth(MaxVertices)) u_stk (.clk, .we(s_we), .waddr(s_wa),
    .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  dfs_ram #(.Width(VW), .Depth(MaxVertices)) u_fin (.clk, .we(f_we), .waddr(f_wa),
    .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  logic in_acc, add_ok;
  logic [VcW-1:0] src_ext, dst_ext;
  assign in_stall = (st_r != S_IDLE) || ov_r;
  assign in_acc   = in_valid && !in_stall;
  assign src_ext  = VcW'(in_src_vertex);
  assign dst_ext  = VcW'(in_dst_vertex);
  assign add_ok   = (src_ext < neff) && (dst_ext < neff) && (ecnt_r < EcW'(MaxEdges));

  // edge word: target, link, link valid
  logic [VW-1:0] tgt;
  logic [VcW-1:0] tgt_ext;
  logic [EW-1:0] nlink;
  logic          nlval;
  logic          take;
  assign tgt     = e_rd[FrW-1:EW+1];
  assign nlink   = e_rd[EW:1];
  assign nlval   = e_rd[0];
  assign tgt_ext = VcW'(tgt);
  assign take    = (tgt_ext < neff) && !visit_r[tgt] && (sp_r < VcW'(MaxVertices));
  assign e_ra    = top_r[EW:1];

  always_comb begin
    st_nxt = st_r;
    h_we = 1'b0; h_wa = in_src_vertex[VW-1:0]; h_wd = ecnt_r[EW-1:0];
    h_ra = in_src_vertex[VW-1:0];
    s_we = 1'b0; s_wa = sp_r[VW-1:0]; s_wd = '0; s_ra = VW'(sp_r - VcW'(1));
    f_we = 1'b0; f_wa = fcnt_r[VW-1:0]; f_wd = top_r[FrW-1:EW+1];
    // hold the read address while the output beat waits
    if (ov_r && out_stall) f_ra = VW'(fcnt_r - VcW'(1) - ok_r);
    else f_ra = VW'(fcnt_r - VcW'(1) - k_r);
    unique case (st_r)
      S_IDLE: if (in_acc) st_nxt = in_cmd ? S_CLR : S_IDLE;
      S_CLR: st_nxt = S_ROOT;
      S_ROOT: begin
        h_ra = root_r[VW-1:0];
        if (root_r >= neff) st_nxt = (fcnt_r == '0) ? S_IDLE : S_EMIT;
        else if (visit_r[root_r[VW-1:0]]) st_nxt = S_ROOT;
        else st_nxt = S_RWAIT;
      end
      S_RWAIT, S_EWAIT: begin
        h_ra = tv_r;
        st_nxt = (st_r == S_RWAIT) ? S_PUSH : S_EDGE;
      end
      S_PUSH: begin
        s_we = 1'b1;
        s_wd = {tv_r, h_rd, hvalid_r[tv_r]};
        st_nxt = S_TOP;
      end
      S_TOP: st_nxt = S_TWAIT;
      S_TWAIT: st_nxt = S_STEP;
      S_STEP: begin
        if (!top_r[0]) begin
          f_we = (fcnt_r < VcW'(MaxVertices));
          st_nxt = (sp_r == VcW'(1)) ? S_ROOT : S_TOP;
        end else st_nxt = S_EWAIT;
        h_ra = tv_r;
      end
      S_EDGE: begin
        // write back advanced cursor
        s_we = 1'b1; s_wa = VW'(sp_r - VcW'(1));
        s_wd = {top_r[FrW-1:EW+1], nlink, nlval};
        h_ra = tgt;
        if (take) st_nxt = S_EMIT2;
        else st_nxt = S_TOP;
      end
      S_EMIT2: begin
        h_ra = tv_r;
        st_nxt = S_PUSH;
      end
      S_EMIT: if (k_r == fcnt_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_IDLE && in_acc && !in_cmd && add_ok) begin
      h_we = 1'b1;
    end
  end

  // edge write happens in the cycle after accept so head read data is available
  logic add_pend_r;
  logic [VW-1:0] add_src_r, add_dst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; vcnt_r <= '0; ecnt_r <= '0; drop_r <= 1'b0;
      hvalid_r <= '0; visit_r <= '0; add_pend_r <= 1'b0;
      root_r <= '0; sp_r <= '0; fcnt_r <= '0; k_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) vcnt_r <= cfg_vertex_count;
      add_pend_r <= 1'b0;
      if (st_r == S_IDLE && in_acc) begin
        if (in_cmd) begin
          visit_r <= '0; root_r <= '0; sp_r <= '0; fcnt_r <= '0; k_r <= '0;
        end else if (!add_ok) drop_r <= 1'b1;
        else begin
          add_pend_r <= 1'b1;
          ecnt_r <= ecnt_r + EcW'(1);
        end
      end
      unique case (st_r)
        S_ROOT: begin
          if (root_r < neff && !visit_r[root_r[VW-1:0]]) begin
            visit_r[root_r[VW-1:0]] <= 1'b1;
            tv_r <= root_r[VW-1:0];
          end
          if (root_r < neff) root_r <= root_r + VcW'(1);
        end
        S_PUSH: sp_r <= sp_r + VcW'(1);
        S_TWAIT: top_r <= s_rd;
        S_STEP: if (!top_r[0]) begin
          if (fcnt_r < VcW'(MaxVertices)) fcnt_r <= fcnt_r + VcW'(1);
          sp_r <= sp_r - VcW'(1);
        end
        S_EDGE: if (take) begin
          visit_r[tgt] <= 1'b1;
          tv_r <= tgt;
        end
        S_EMIT: if (!out_valid || !out_stall) begin
          if (k_r != fcnt_r) k_r <= k_r + VcW'(1);
        end
        default: ;
      endcase
      if (add_pend_r) hvalid_r[add_src_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      add_src_r <= in_src_vertex[VW-1:0];
      add_dst_r <= in_dst_vertex[VW-1:0];
    end
  end

  // edge store write, in the cycle after the head read
  logic [EW-1:0] eidx;
  assign eidx = ecnt_r[EW-1:0] - EW'(1);
  assign e_we = add_pend_r;
  assign e_wa = eidx;
  assign e_wd = {add_dst_r, h_rd, hvalid_r[add_src_r]};

  // output register: read issued in S_EMIT, data lands next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (!ov_r || !out_stall) begin
      ov_r <= (st_r == S_EMIT) && (k_r != fcnt_r);
      ok_r <= k_r;
      olast_r <= (k_r + VcW'(1) == fcnt_r);
    end
  end
  assign out_valid = ov_r;
  assign out_vertex_id = VidW'(f_rd);
  assign out_last_of_order = olast_r;
  assign out_edges_dropped = drop_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= VcW'(MaxVertices)) else $error("stack overflow");
  a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= VcW'(MaxVertices)) else $error("finish overflow");
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |=> !($rose(out_valid) && $past(st_r) == S_IDLE))
    else $error("spurious output");
endmodule
`default_nettype wire

FILE: rtl/dfs_ram.sv
`default_nettype none
module dfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: test/tb_checker.sv
`timescale 1ns / 100ps
module tb_checker
  import dfs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [CntW-1:0] cfg_vertex_count,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic            in_cmd,
  input  logic [VidW-1:0] in_src_vertex,
  input  logic [VidW-1:0] in_dst_vertex,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [VidW-1:0] out_vertex_id,
  input  logic            out_last_of_order,
  input  logic            out_edges_dropped,
  output int              fail_count,
  output int              order_pending
);
  localparam int NV = DefMaxVertices;
  localparam int NE = DefMaxEdges;

  typedef struct packed {
    logic [VidW-1:0] vertex_id;
    logic            last;
    logic            dropped;
  } order_beat_t;

  order_beat_t order_q[$];

  logic [CntW-1:0] num_vertices;
  logic [8:0]      first_edge[NV];
  bit              first_ok[NV];
  logic [VidW-1:0] edge_dst[NE];
  logic [8:0]      next_edge[NE];
  bit              next_ok[NE];
  int              stored_edges;
  bit              any_dropped;

  function automatic int active_vertices();
    return (num_vertices > NV) ? NV : int'(num_vertices);
  endfunction

  task automatic store_edge(input logic [VidW-1:0] src, input logic [VidW-1:0] dst);
    int n;
    n = active_vertices();
    if (src >= n || dst >= n || stored_edges >= NE) begin
      any_dropped = 1'b1;
    end else begin
      edge_dst[stored_edges]  = dst;
      next_edge[stored_edges] = first_edge[src];
      next_ok[stored_edges]   = first_ok[src];
      first_edge[src]         = stored_edges[8:0];
      first_ok[src]           = 1'b1;
      stored_edges++;
    end
  endtask

  // iterative dfs, emit reverse finish order
  task automatic predict_order();
    int n, done_cnt, sp, e, t;
    bit seen[NV];
    int frame_v[NV];
    int frame_e[NV];
    bit frame_ok[NV];
    int finished[NV];
    order_beat_t b;
    n = active_vertices();
    done_cnt = 0;
    for (int v = 0; v < NV; v++) seen[v] = 1'b0;
    for (int root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root]  = 1'b1;
        frame_v[0]  = root;
        frame_e[0]  = first_edge[root];
        frame_ok[0] = first_ok[root];
        sp = 1;
        while (sp > 0) begin
          if (!frame_ok[sp-1] || frame_e[sp-1] >= NE) begin
            if (done_cnt < NV) begin
              finished[done_cnt] = frame_v[sp-1];
              done_cnt++;
            end
            sp--;
          end else begin
            e = frame_e[sp-1];
            frame_e[sp-1]  = next_edge[e];
            frame_ok[sp-1] = next_ok[e];
            t = edge_dst[e];
            if (t < n && !seen[t] && sp < NV) begin
              seen[t]      = 1'b1;
              frame_v[sp]  = t;
              frame_e[sp]  = first_edge[t];
              frame_ok[sp] = first_ok[t];
              sp++;
            end
          end
        end
      end
    end
    for (int k = 0; k < done_cnt; k++) begin
      b.vertex_id = finished[done_cnt-1-k][VidW-1:0];
      b.last      = (k + 1 == done_cnt);
      b.dropped   = any_dropped;
      order_q.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    order_beat_t exp_b;
    if (!rst_n) begin
      num_vertices = '0;
      stored_edges = 0;
      any_dropped  = 1'b0;
      for (int v = 0; v < NV; v++) first_ok[v] = 1'b0;
      order_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (order_q.size() == 0) begin
          $error("unexpected beat: vertex_id=%0d", out_vertex_id);
          fail_count++;
        end else begin
          exp_b = order_q.pop_front();
          if (out_vertex_id !== exp_b.vertex_id) begin
            $error("vertex_id expected %0d actual %0d", exp_b.vertex_id, out_vertex_id);
            fail_count++;
          end
          if (out_last_of_order !== exp_b.last) begin
            $error("last_of_order expected %0d actual %0d", exp_b.last, out_last_of_order);
            fail_count++;
          end
          if (out_edges_dropped !== exp_b.dropped) begin
            $error("edges_dropped expected %0d actual %0d", exp_b.dropped,
                   out_edges_dropped);
            fail_count++;
          end
        end
      end
      if (cfg_we) num_vertices = cfg_vertex_count;
      if (in_valid && !in_stall) begin
        if (in_cmd) predict_order();
        else store_edge(in_src_vertex, in_dst_vertex);
      end
    end
    order_pending = order_q.size();
  end

  initial begin
    fail_count    = 0;
    order_pending = 0;
  end
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
module tb_top
  import dfs_pkg::*;
();

  localparam bit CMD_ADD  = 1'b0;
  localparam bit CMD_SORT = 1'b1;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [CntW-1:0] cfg_vertex_count = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            in_cmd = 1'b0;
  logic [VidW-1:0] in_src_vertex = '0;
  logic [VidW-1:0] in_dst_vertex = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [VidW-1:0] out_vertex_id;
  logic            out_last_of_order;
  logic            out_edges_dropped;
  int              fail_count;
  int              order_pending;
  bit              no_idle = 1'b0;
  int              cur_count;

  always #5 clk = ~clk;

  dfs_topological_sort dut (.*);

  tb_checker chk (.*);

  // sink side stalls at random unless in a no-idle stretch
  always @(negedge clk) out_stall <= !no_idle && ($urandom_range(99) < 37);

  task automatic send_beat(input bit cmd, input int src, input int dst);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_src_vertex <= src[VidW-1:0];
    in_dst_vertex <= dst[VidW-1:0];
    #1;
    while (in_stall) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
  endtask

  // let the order drain and the block settle, then write the vertex count
  task automatic set_count(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    while (order_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    cfg_we           <= 1'b1;
    cfg_vertex_count <= n[CntW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_count = n;
  endtask

  task automatic random_edge();
    int lim;
    lim = (cur_count > 64) ? 64 : cur_count;
    if (lim == 0 || $urandom_range(9) == 0)
      send_beat(CMD_ADD, $urandom_range(63), $urandom_range(63));
    else
      send_beat(CMD_ADD, $urandom_range(lim - 1), $urandom_range(lim - 1));
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed
    set_count(0);
    send_beat(CMD_SORT, 0, 0);
    send_beat(CMD_ADD, 0, 0);
    set_count(5);
    send_beat(CMD_ADD, 0, 1);
    send_beat(CMD_ADD, 0, 2);
    send_beat(CMD_ADD, 1, 3);
    send_beat(CMD_ADD, 2, 3);
    send_beat(CMD_ADD, 3, 4);
    send_beat(CMD_ADD, 4, 1);
    send_beat(CMD_SORT, 63, 63);
    send_beat(CMD_ADD, 5, 0);
    send_beat(CMD_ADD, 0, 63);
    send_beat(CMD_SORT, 0, 0);
    set_count(64);
    send_beat(CMD_ADD, 63, 0);
    send_beat(CMD_ADD, 0, 63);
    send_beat(CMD_SORT, 42, 21);
    set_count(127);
    send_beat(CMD_SORT, 0, 0);
    // count lowered below stored targets
    set_count(3);
    send_beat(CMD_SORT, 0, 0);
    set_count(1);
    send_beat(CMD_SORT, 0, 0);

    // random phases, each closed by a sort
    for (int ph = 0; ph < 10; ph++) begin
      no_idle = (ph == 4);
      if (ph % 4 == 3) set_count(65 + $urandom_range(62));
      else if (ph == 7) set_count(64);
      else set_count($urandom_range(64));
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(9) == 0) send_beat(CMD_SORT, $urandom_range(63), $urandom_range(63));
        else random_edge();
      end
      send_beat(CMD_SORT, $urandom_range(63), $urandom_range(63));
    end
    no_idle = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (order_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
